[hdl/phm_pkg.sv]
// Package: shared constants and types for the pixel history median block.
`default_nettype none
package phm_pkg;
  localparam int PIXELS = 4096;
  localparam int MAX_DEPTH = 16;
  localparam int PIX_W = 12;
  localparam int DEP_W = $clog2(MAX_DEPTH);
  localparam int CNT_W = 5;
  localparam int ADDR_W = PIX_W + DEP_W;
  localparam int ENT_W = 48;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_MEDIAN = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;  // unused code, ignored

  // commands from controller to datapath
  typedef struct packed {
    logic             load;     // capture request fields
    logic             rd_en;    // issue history read
    logic [DEP_W-1:0] rd_idx;
    logic             cnt_rd;   // issue count read
    logic             wr_en;    // write history entry
    logic [DEP_W-1:0] wr_idx;
    logic             wr_new;   // write the new sample (else the shifted entry)
    logic             hold_prev; // latch read data as shift carry
    logic             cnt_wr;
    logic [CNT_W-1:0] cnt_val;
    logic             init;     // count write goes to init_px (clearing pass)
    logic [PIX_W-1:0] init_px;
    logic             sort_clr; // clear channel sort buffers
    logic             sort_ins; // insert read entry into sort buffers
    logic             res_calc; // compute median result
  } phm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0]       req;
    logic [CNT_W-1:0] cnt;
    logic             le;       // new motion <= read motion
  } phm_sts_t;
endpackage
`default_nettype wire

[hdl/pixel_history_median.sv]
// Top level: pixel history median block.
// Per-pixel sorted history store with median read-out. After reset the block zeroes
// every entry of its count memory before the first request is taken. One request is
// handled at a time. The history memory has a single read port and is walked one
// entry at a time. A result is held until taken, and no new request or configuration
// write is accepted until then.
`default_nettype none
module pixel_history_median (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [11:0] in_pixel_index,
  input  wire logic [23:0] in_motion_amount,
  input  wire logic [23:0] in_pixel_rgb,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_background_rgb,
  output logic             out_history_empty,
  output logic [4:0]       out_entries_used,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_median_size
);
  import phm_pkg::*;
  phm_cmd_t cmd;
  phm_sts_t sts;
  logic [4:0] n;
  logic empty;
  logic [23:0] rgb;

  phm_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cfg_valid, .cfg_ready, .cfg_median_size, .sts, .cmd, .n_r(n), .empty_r(empty));
  phm_datapath u_dp (.clk, .cmd, .sts, .in_req_type, .in_pixel_index,
    .in_motion_amount, .in_pixel_rgb, .n_used(n), .res_rgb(rgb));

  assign out_background_rgb = empty ? 24'd0 : rgb;
  assign out_history_empty = empty;
  assign out_entries_used = n;
endmodule
`default_nettype wire

[hdl/phm_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module phm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/phm_datapath.sv]
// Datapath: history and count memories, shift carry, channel sort buffers, median.
`default_nettype none
module phm_datapath (
  input  wire logic                  clk,
  input  wire phm_pkg::phm_cmd_t     cmd,
  output phm_pkg::phm_sts_t          sts,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [11:0]           in_pixel_index,
  input  wire logic [23:0]           in_motion_amount,
  input  wire logic [23:0]           in_pixel_rgb,
  input  wire logic [4:0]            n_used,
  output logic [23:0]                res_rgb
);
  import phm_pkg::*;

  logic [1:0]        req_r;
  logic [PIX_W-1:0]  px_r;
  logic [23:0]       mot_r, rgb_r;
  logic [ENT_W-1:0]  rd_data, carry_r, wdata;
  logic [CNT_W-1:0]  cnt_rd;
  logic [7:0]        sbuf_r [3][MAX_DEPTH];
  logic [DEP_W:0]    sn_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      px_r  <= in_pixel_index;
      mot_r <= in_motion_amount;
      rgb_r <= in_pixel_rgb;
    end
    if (cmd.hold_prev) carry_r <= rd_data;
  end

  assign wdata = cmd.wr_new ? {mot_r, rgb_r} : carry_r;

  phm_ram #(.WIDTH(ENT_W), .DEPTH(PIXELS*MAX_DEPTH)) u_hist (
    .clk(clk), .we(cmd.wr_en), .waddr({px_r, cmd.wr_idx}), .wdata(wdata),
    .re(cmd.rd_en), .raddr({px_r, cmd.rd_idx}), .rdata(rd_data));

  // count memory; the controller zeroes it with a clearing pass after reset
  phm_ram #(.WIDTH(CNT_W), .DEPTH(PIXELS)) u_cnt (
    .clk(clk), .we(cmd.cnt_wr), .waddr(cmd.init ? cmd.init_px : px_r),
    .wdata(cmd.cnt_val), .re(cmd.cnt_rd), .raddr(px_r), .rdata(cnt_rd));

  assign sts.req   = req_r;
  assign sts.cnt   = cnt_rd;
  assign sts.le    = mot_r <= rd_data[47:24];

  // insertion sort of each channel, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.sort_clr) sn_r <= '0;
    else if (cmd.sort_ins) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < MAX_DEPTH; j++) begin
          logic [7:0] x;
          logic [7:0] prv;
          x = rd_data[c*8 +: 8];
          prv = sbuf_r[c][(j > 0) ? j - 1 : 0];
          if ((DEP_W+1)'(j) < sn_r) begin
            if (sbuf_r[c][j] > x) begin
              if (j == 0 || prv <= x) sbuf_r[c][j] <= x;
              else sbuf_r[c][j] <= prv;
            end
          end else if ((DEP_W+1)'(j) == sn_r) begin
            if (j > 0 && prv > x) sbuf_r[c][j] <= prv;
            else sbuf_r[c][j] <= x;
          end
        end
      end
      sn_r <= sn_r + 1'b1;
    end
  end

  // median pick
  always_ff @(posedge clk) begin
    if (cmd.res_calc) begin
      for (int c = 0; c < 3; c++) begin
        logic [DEP_W-1:0] m;
        logic [8:0] s;
        m = DEP_W'(n_used >> 1);
        if (n_used[0]) res_rgb[c*8 +: 8] <= sbuf_r[c][m];
        else begin
          s = {1'b0, sbuf_r[c][m - 1'b1]} + {1'b0, sbuf_r[c][m]};
          res_rgb[c*8 +: 8] <= s[8:1];
        end
      end
    end
  end
endmodule
`default_nettype wire

[hdl/phm_ctrl.sv]
// Controller: sequences insert shifts, clears and median reads over the history.
`default_nettype none
module phm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [4:0]        cfg_median_size,
  input  wire phm_pkg::phm_sts_t sts,
  output phm_pkg::phm_cmd_t      cmd,
  output logic [4:0]             n_r,
  output logic                   empty_r
);
  import phm_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CNT, S_DEC, S_SRCH, S_PUT, S_SHIFT, S_NEW, S_MRD, S_MCALC, S_OUT
  } state_t;

  state_t           st_r, st_nxt;
  logic [4:0]       msize_r, cap;
  logic [CNT_W-1:0] cnt_r, newcnt_r, cnt_clip;
  logic [DEP_W:0]   i_r, i_nxt, j_r, j_nxt;
  logic [DEP_W:0]   pos_r, pos_nxt;
  logic             rdp_r, rdp_nxt;
  logic [4:0]       n_nxt;
  logic             ov_r, ov_nxt;
  logic [PIX_W-1:0] init_r;

  assign cap = (msize_r == 5'd0) ? 5'd1 :
               (msize_r > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : msize_r;
  assign cnt_clip = (sts.cnt > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : sts.cnt;
  assign in_ready = st_r == S_IDLE && !ov_r;
  assign cfg_ready = st_r == S_IDLE && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; pos_nxt = pos_r;
    rdp_nxt = 1'b0; n_nxt = n_r; ov_nxt = ov_r && !out_ready;
    case (st_r)
      S_INIT: begin
        // zero one count entry per cycle
        cmd.init = 1'b1; cmd.init_px = init_r;
        cmd.cnt_wr = 1'b1; cmd.cnt_val = '0;
        if (init_r == PIX_W'(PIXELS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) begin cmd.load = 1'b1; st_nxt = S_CNT; end
      S_CNT: begin cmd.cnt_rd = 1'b1; st_nxt = S_DEC; end
      S_DEC: begin
        i_nxt = '0; pos_nxt = (DEP_W+1)'(cnt_clip);
        case (sts.req)
          REQ_INSERT: begin
            if (cnt_clip != '0) begin
              cmd.rd_en = 1'b1; cmd.rd_idx = '0; rdp_nxt = 1'b1;
            end
            st_nxt = (cnt_clip != '0) ? S_SRCH : S_PUT;
          end
          REQ_CLEAR: begin cmd.cnt_wr = 1'b1; cmd.cnt_val = '0; st_nxt = S_IDLE; end
          REQ_MEDIAN: begin
            n_nxt = (sts.cnt > cap) ? cap : sts.cnt;
            cmd.sort_clr = 1'b1;
            st_nxt = S_MRD;
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_SRCH: begin
        // read of entry i_r is in rd_data
        if (sts.le) begin
          pos_nxt = i_r;
          st_nxt = S_PUT;
        end else if (i_r + 1'b1 < (DEP_W+1)'(cnt_r)) begin
          i_nxt = i_r + 1'b1; cmd.rd_en = 1'b1; cmd.rd_idx = DEP_W'(i_r + 1'b1);
          rdp_nxt = 1'b1;
        end else begin
          pos_nxt = (DEP_W+1)'(cnt_r); st_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (pos_r < (DEP_W+1)'(cnt_r)) begin
          // shift from the last kept entry down to pos
          j_nxt = (DEP_W+1)'(newcnt_r) - 1'b1;
          st_nxt = S_SHIFT;
          if (j_nxt == pos_r) begin
            cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_idx = DEP_W'(pos_r);
            cmd.cnt_wr = 1'b1; cmd.cnt_val = newcnt_r; st_nxt = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1; cmd.rd_idx = DEP_W'(j_nxt - 1'b1); rdp_nxt = 1'b1;
          end
        end else begin
          if (cnt_r < cap) begin
            cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_idx = DEP_W'(cnt_r);
            cmd.cnt_wr = 1'b1; cmd.cnt_val = cnt_r + 1'b1;
          end
          st_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        // rd_data holds entry j-1: latch it, then write it to j
        if (rdp_r) begin
          cmd.hold_prev = 1'b1;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_idx = DEP_W'(j_r);
          j_nxt = j_r - 1'b1;
          if (j_nxt == pos_r) begin
            st_nxt = S_NEW;
          end else begin
            cmd.rd_en = 1'b1; cmd.rd_idx = DEP_W'(j_nxt - 1'b1); rdp_nxt = 1'b1;
          end
        end
      end
      S_NEW: begin
        // new sample into the opened slot
        cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; cmd.wr_idx = DEP_W'(pos_r);
        cmd.cnt_wr = 1'b1; cmd.cnt_val = newcnt_r; st_nxt = S_IDLE;
      end
      S_MRD: begin
        if (rdp_r) cmd.sort_ins = 1'b1;
        if (i_r < (DEP_W+1)'(n_r)) begin
          cmd.rd_en = 1'b1; cmd.rd_idx = DEP_W'(i_r); rdp_nxt = 1'b1; i_nxt = i_r + 1'b1;
        end else if (!rdp_r) st_nxt = S_MCALC;
      end
      S_MCALC: begin
        cmd.res_calc = 1'b1; st_nxt = S_OUT;
      end
      S_OUT: begin ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; ov_r <= 1'b0; msize_r <= 5'd16; rdp_r <= 1'b0; init_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) msize_r <= cfg_median_size;
      st_r <= st_nxt; pos_r <= pos_nxt;
      ov_r <= ov_nxt; rdp_r <= rdp_nxt;
      i_r <= i_nxt; j_r <= j_nxt; n_r <= n_nxt;
      if (st_r == S_INIT) init_r <= init_r + 1'b1;
      if (st_r == S_DEC) begin
        cnt_r <= cnt_clip;
        newcnt_r <= (cnt_clip < cap) ? cnt_clip + 1'b1 : cnt_clip;
      end
    end
  end

  assign empty_r = n_r == 5'd0;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
endmodule
`default_nettype wire

[verif/pixel_history_median_tb.sv]
// Testbench for pixel_history_median: random and directed requests against a built-in predictor.
`default_nettype none
module pixel_history_median_tb;
  import phm_pkg::*;

  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES  = 80;

  // Sorted-history predictor plus the queue of expected medians
  class median_scoreboard;
    typedef struct {
      logic [23:0] rgb;
      logic        empty;
      logic [4:0]  used;
    } median_t;

    logic [23:0] hist_motion [PIXELS][MAX_DEPTH];
    logic [23:0] hist_rgb [PIXELS][MAX_DEPTH];
    int          fill [PIXELS];
    logic [4:0]  size_reg;
    median_t     expected_q[$];
    int          errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      size_reg = 5'd16;
      errors = 0;
    endfunction

    function int depth_limit();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_DEPTH) return MAX_DEPTH;
      return size_reg;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // median of one 8-bit channel over the first n entries
    function logic [7:0] chan_median(int px, int n, int sh);
      int v[MAX_DEPTH];
      int x, j;
      for (int i = 0; i < n; i++) begin
        x = (hist_rgb[px][i] >> sh) & 8'hFF;
        j = i;
        while (j > 0 && v[j-1] > x) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = x;
      end
      if (n % 2) return 8'(v[n/2]);
      return 8'((v[n/2-1] + v[n/2]) >> 1);
    endfunction

    // apply one accepted request to the predicted state
    function void note_request(logic [1:0] req, int px, logic [23:0] mot, logic [23:0] rgb);
      int cap, cnt, pos, newcnt, n;
      median_t m;
      cap = depth_limit();
      cnt = fill[px];
      if (req == REQ_INSERT) begin
        pos = cnt;
        for (int i = 0; i < cnt; i++)
          if (mot <= hist_motion[px][i]) begin
            pos = i;
            break;
          end
        if (pos < cnt) begin
          newcnt = (cnt < cap) ? cnt + 1 : cnt;
          for (int j = newcnt - 1; j > pos; j--) begin
            hist_motion[px][j] = hist_motion[px][j-1];
            hist_rgb[px][j] = hist_rgb[px][j-1];
          end
          hist_motion[px][pos] = mot;
          hist_rgb[px][pos] = rgb;
          fill[px] = newcnt;
        end else if (cnt < cap) begin
          hist_motion[px][cnt] = mot;
          hist_rgb[px][cnt] = rgb;
          fill[px] = cnt + 1;
        end
      end else if (req == REQ_CLEAR) begin
        fill[px] = 0;
      end else if (req == REQ_MEDIAN) begin
        n = (cnt > cap) ? cap : cnt;
        m.rgb = 24'd0;
        if (n > 0)
          m.rgb = {chan_median(px, n, 16), chan_median(px, n, 8), chan_median(px, n, 0)};
        m.empty = (n == 0);
        m.used = n[4:0];
        expected_q = {expected_q, m};
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [23:0] rgb, logic empty, logic [4:0] used);
      median_t m;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result rgb=%h empty=%b used=%0d", rgb, empty, used);
        return;
      end
      m = expected_q.pop_front();
      if (rgb !== m.rgb || empty !== m.empty || used !== m.used) begin
        errors++;
        if (errors <= 10)
          $display("median error: exp rgb=%h empty=%b used=%0d, got rgb=%h empty=%b used=%0d",
                   m.rgb, m.empty, m.used, rgb, empty, used);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_INSERT;
  logic [11:0] in_pixel_index = '0;
  logic [23:0] in_motion_amount = '0;
  logic [23:0] in_pixel_rgb = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_background_rgb;
  logic        out_history_empty;
  logic [4:0]  out_entries_used;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_median_size = 5'd16;

  median_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  pixel_history_median dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_pixel_index, .in_motion_amount, .in_pixel_rgb,
    .out_valid, .out_ready, .out_background_rgb, .out_history_empty, .out_entries_used,
    .cfg_valid, .cfg_ready, .cfg_median_size
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_background_rgb, out_history_empty, out_entries_used);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("pixel_history_median: mismatch");
      $finish;
    end
  end

  // one request; called and returning at a falling edge
  task automatic send_request(logic [1:0] req, logic [11:0] px, logic [23:0] mot,
                              logic [23:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pixel_index <= px;
    in_motion_amount <= mot;
    in_pixel_rgb <= rgb;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, px, mot, rgb);
    @(negedge clk);
  endtask

  // wait until the block is idle, then write the capacity register
  task automatic write_size(logic [4:0] val);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_median_size <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.size_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    logic [11:0] px;
    logic [23:0] mot;
    pick = $urandom_range(99);
    px = ($urandom_range(19) == 0) ? 12'($urandom) : 12'($urandom_range(7));
    mot = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(15));
    if (pick < 62)      send_request(REQ_INSERT, px, mot, 24'($urandom));
    else if (pick < 90) send_request(REQ_MEDIAN, px, 24'($urandom), 24'($urandom));
    else if (pick < 97) send_request(REQ_CLEAR, px, 24'($urandom), 24'($urandom));
    else                send_request(REQ_NONE, px, 24'($urandom), 24'($urandom));
  endtask

  initial begin
    logic [4:0] sizes[4];
    sizes = '{5'd0, 5'd31, 5'd1, 5'($urandom_range(2, 16))};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, field extremes, equal keys, full list and discard
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    send_request(REQ_INSERT, 12'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_request(REQ_INSERT, 12'd0, 24'd0, 24'd0);
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    send_request(REQ_INSERT, 12'd0, 24'd0, 24'h123456);
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    for (int i = 0; i < 14; i++)
      send_request(REQ_INSERT, 12'd0, 24'(i * 3), 24'($urandom));
    send_request(REQ_INSERT, 12'd0, 24'hFFFFFF, 24'hABCDEF);
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    send_request(REQ_INSERT, 12'd4095, 24'd5, 24'h00FF00);
    send_request(REQ_MEDIAN, 12'd4095, 24'hFFFFFF, 24'hFFFFFF);
    send_request(REQ_NONE, 12'd4095, 24'd1, 24'd1);
    send_request(REQ_CLEAR, 12'd4095, 24'd0, 24'd0);
    send_request(REQ_MEDIAN, 12'd4095, 24'd0, 24'd0);

    // capacity dropped below a full list
    write_size(5'd3);
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    send_request(REQ_INSERT, 12'd0, 24'd1, 24'h808080);
    send_request(REQ_MEDIAN, 12'd0, 24'd0, 24'd0);
    send_request(REQ_CLEAR, 12'd0, 24'd0, 24'd0);

    // random phases, each with its own capacity and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      write_size(sizes[ph]);
      for (int p = 0; p < 8; p++) send_request(REQ_CLEAR, 12'(p), 24'd0, 24'd0);
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 79) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 79) : 0;
      for (int k = 0; k < 245; k++) random_request();
    end
    write_size(5'd16);
    send_idle_pct = 0;
    for (int k = 0; k < 40; k++) random_request();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pixel_history_median: match");
    end else begin
      $display("pixel_history_median: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
